### rtl/hybrid_quicksort_insertion_core_defines.svh
`ifndef HYBRID_QUICKSORT_INSERTION_CORE_DEFINES_SVH
`define HYBRID_QUICKSORT_INSERTION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HQIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HQIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hqic_pkg.sv
package hqic_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int LIMIT_W        = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

	typedef struct packed {
		logic signed [FIELD_W-1:0] item_value;
		logic                      item_last;
	} item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] sorted_value;
		logic                      sorted_last;
		logic                      overflowed;
	} result_t;

endpackage

### rtl/hqic_ram.sv
module hqic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/hybrid_quicksort_insertion_core.sv
// Load: one item per cycle, busy stays low until an item marked last arrives.
// Sort: separate insertion and partition comparators on a one-read, one-write value store; ranges
// no larger than the range limit are insertion-sorted, larger ones are partitioned.
// Emit: n results on consecutive cycles, each read from the value store and registered with its strobe.
// Results cannot be held off; busy falls in the cycle after the last result strobe.
// Async reset clears counts, stack and flags, and sets the range limit to 16.
`include "hybrid_quicksort_insertion_core_defines.svh"

module hybrid_quicksort_insertion_core
	import hqic_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               start,
	input  item_t              item,
	output logic               busy,
	output logic               result_strobe,
	output result_t            result
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;
	localparam int STK_W = 2 * IDX_W;

	typedef enum logic [16:0] {
		S_IDLE       = 17'h00001,
		S_POP        = 17'h00002,
		S_RANGE      = 17'h00004,
		S_INS_I      = 17'h00008,
		S_INS_KEY    = 17'h00010,
		S_INS_CMP    = 17'h00020,
		S_INS_PUT    = 17'h00040,
		S_PART_PIV   = 17'h00080,
		S_PART_RD    = 17'h00100,
		S_PART_CMP   = 17'h00200,
		S_PART_SW    = 17'h00400,
		S_PART_SW2   = 17'h00800,
		S_PART_F1    = 17'h01000,
		S_PART_F2    = 17'h02000,
		S_PART_PUSH2 = 17'h04000,
		S_EMIT       = 17'h08000,
		S_FINISH     = 17'h10000
	} state_t;

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]    lim_q;
	logic [CNT_W-1:0]      count_q, n_q, top_q, i_q, k_q;
	logic [IDX_W-1:0]      lo_q, hi_q, j_q, ip_q;
	logic                  dropped_q;
	logic [VALUE_BITS-1:0] key_q, pivot_q, vj_q;
	logic                  res_v_s1, res_last_s1, res_ovf_s1;

	logic                  st_we;
	logic [IDX_W-1:0]      st_waddr, st_raddr;
	logic [VALUE_BITS-1:0] st_wdata, st_rdata;
	logic                  stk_we;
	logic [IDX_W-1:0]      stk_raddr;
	logic [STK_W-1:0]      stk_wdata, stk_rdata;

	logic                  accept, room, ins_less, part_less, small_rng;
	logic [63:0]           in_ext, out_ext;
	logic [VALUE_BITS-1:0] in_val;
	logic [CNT_W-1:0]      n_load, n_load_m1, n_m1, top_dec, i_m1, size;
	logic [IDX_W-1:0]      rlo, rhi;
	logic                  push_hi, push_lo;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign room    = (count_q < CNT_W'(CAPACITY));
	assign in_ext  = 64'($unsigned(item.item_value));
	assign in_val  = in_ext[VALUE_BITS-1:0];
	assign n_load  = count_q + CNT_W'(room);
	assign n_load_m1 = n_load - 1'b1;
	assign n_m1    = n_q - 1'b1;
	assign top_dec = top_q - 1'b1;
	assign i_m1    = i_q - 1'b1;
	assign rlo     = stk_rdata[STK_W-1:IDX_W];
	assign rhi     = stk_rdata[IDX_W-1:0];
	assign size    = CNT_W'(rhi) - CNT_W'(rlo) + 1'b1;
	assign small_rng = (8'(size) <= 8'(lim_q));
	assign ins_less  = ($signed(key_q) < $signed(st_rdata));
	assign part_less = ($signed(st_rdata) < $signed(pivot_q));
	assign push_hi = (CNT_W'(hi_q) >= CNT_W'(ip_q) + CNT_W'(2))
		&& (top_q < CNT_W'(CAPACITY));
	assign push_lo = (CNT_W'(ip_q) >= CNT_W'(lo_q) + CNT_W'(2))
		&& (top_q < CNT_W'(CAPACITY));

	always_comb begin
		state_d   = state_q;
		st_we     = 1'b0;
		st_waddr  = count_q[IDX_W-1:0];
		st_wdata  = in_val;
		st_raddr  = k_q[IDX_W-1:0];
		stk_we    = 1'b0;
		stk_wdata = {lo_q, hi_q};
		stk_raddr = top_dec[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					st_we = room;
					if (item.item_last) begin
						if (n_load >= CNT_W'(2)) begin
							stk_we    = 1'b1;
							stk_wdata = {IDX_W'(0), n_load_m1[IDX_W-1:0]};
						end
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				state_d = (top_q == '0) ? S_EMIT : S_RANGE;
			end
			S_RANGE: begin
				st_raddr = rhi;
				state_d  = small_rng ? S_INS_I : S_PART_PIV;
			end
			S_INS_I: begin
				st_raddr = i_q[IDX_W-1:0];
				state_d  = (i_q > CNT_W'(hi_q)) ? S_POP : S_INS_KEY;
			end
			S_INS_KEY: begin
				st_raddr = i_m1[IDX_W-1:0];
				state_d  = S_INS_CMP;
			end
			S_INS_CMP: begin
				st_we    = 1'b1;
				st_waddr = j_q + 1'b1;
				st_raddr = j_q - 1'b1;
				if (ins_less) begin
					// shift the larger entry up one slot
					st_wdata = st_rdata;
					state_d  = (j_q == lo_q) ? S_INS_PUT : S_INS_CMP;
				end else begin
					st_wdata = key_q;
					state_d  = S_INS_I;
				end
			end
			S_INS_PUT: begin
				st_we    = 1'b1;
				st_waddr = lo_q;
				st_wdata = key_q;
				state_d  = S_INS_I;
			end
			S_PART_PIV: begin
				state_d = S_PART_RD;
			end
			S_PART_RD: begin
				if (j_q == hi_q) begin
					st_raddr = ip_q;
					state_d  = S_PART_F1;
				end else begin
					st_raddr = j_q;
					state_d  = S_PART_CMP;
				end
			end
			S_PART_CMP: begin
				st_raddr = ip_q;
				if (part_less && (ip_q != j_q)) begin
					state_d = S_PART_SW;
				end else begin
					state_d = S_PART_RD;
				end
			end
			S_PART_SW: begin
				st_we    = 1'b1;
				st_waddr = j_q;
				st_wdata = st_rdata;
				state_d  = S_PART_SW2;
			end
			S_PART_SW2: begin
				st_we    = 1'b1;
				st_waddr = ip_q;
				st_wdata = vj_q;
				state_d  = S_PART_RD;
			end
			S_PART_F1: begin
				st_we    = 1'b1;
				st_waddr = hi_q;
				st_wdata = st_rdata;
				state_d  = S_PART_F2;
			end
			S_PART_F2: begin
				st_we     = 1'b1;
				st_waddr  = ip_q;
				st_wdata  = pivot_q;
				stk_we    = push_hi;
				stk_wdata = {ip_q + 1'b1, hi_q};
				state_d   = S_PART_PUSH2;
			end
			S_PART_PUSH2: begin
				stk_we    = push_lo;
				stk_wdata = {lo_q, ip_q - 1'b1};
				state_d   = S_POP;
			end
			S_EMIT: begin
				state_d = (k_q == n_m1) ? S_FINISH : S_EMIT;
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lim_q       <= LIMIT_RESET;
			count_q     <= '0;
			n_q         <= '0;
			top_q       <= '0;
			i_q         <= '0;
			k_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			j_q         <= '0;
			ip_q        <= '0;
			dropped_q   <= 1'b0;
			res_v_s1    <= 1'b0;
			res_last_s1 <= 1'b0;
			res_ovf_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			res_v_s1 <= (state_q == S_EMIT);
			if (cfg_wr_en) begin
				lim_q <= cfg_wr_data;
			end
			if ((state_q == S_POP) && (top_q != '0)) begin
				top_q <= top_dec;
			end else if (stk_we) begin
				top_q <= top_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (item.item_last) begin
							n_q <= n_load;
							k_q <= '0;
						end
					end
				end
				S_RANGE: begin
					lo_q <= rlo;
					hi_q <= rhi;
					i_q  <= CNT_W'(rlo) + 1'b1;
					j_q  <= rlo;
					ip_q <= rlo;
				end
				S_INS_KEY: begin
					j_q <= i_m1[IDX_W-1:0];
				end
				S_INS_CMP: begin
					if (!ins_less) begin
						i_q <= i_q + 1'b1;
					end else if (j_q != lo_q) begin
						j_q <= j_q - 1'b1;
					end
				end
				S_INS_PUT: begin
					i_q <= i_q + 1'b1;
				end
				S_PART_CMP: begin
					if (!part_less) begin
						j_q <= j_q + 1'b1;
					end else if (ip_q == j_q) begin
						ip_q <= ip_q + 1'b1;
						j_q  <= j_q + 1'b1;
					end
				end
				S_PART_SW2: begin
					ip_q <= ip_q + 1'b1;
					j_q  <= j_q + 1'b1;
				end
				S_EMIT: begin
					res_last_s1 <= (k_q == n_m1);
					res_ovf_s1  <= dropped_q;
					k_q         <= k_q + 1'b1;
				end
				S_FINISH: begin
					count_q   <= '0;
					dropped_q <= 1'b0;
					top_q     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// hold compare operands
	always_ff @(posedge clk) begin
		if (state_q == S_INS_KEY) begin
			key_q <= st_rdata;
		end
		if (state_q == S_PART_PIV) begin
			pivot_q <= st_rdata;
		end
		if (state_q == S_PART_CMP) begin
			vj_q <= st_rdata;
		end
	end

	hqic_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_value_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	hqic_ram #(
		.WIDTH (STK_W),
		.DEPTH (CAPACITY)
	) u_range_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (top_q[IDX_W-1:0]),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign out_ext              = 64'(st_rdata);
	assign result_strobe        = res_v_s1;
	assign result.sorted_value  = out_ext[FIELD_W-1:0];
	assign result.sorted_last   = res_last_s1;
	assign result.overflowed    = res_ovf_s1;

	`HQIC_ASSERT_NOW(a_strobe_busy, result_strobe, busy, "result item outside a busy phase")
	`HQIC_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "item count above capacity")
	`HQIC_ASSERT_NOW(a_top_cap, 1'b1, top_q <= CNT_W'(CAPACITY), "range stack overrun")
	`HQIC_ASSERT_NEXT(a_last_busy, accept && item.item_last, busy, "last item did not start sort")

endmodule
